@@ rtl/psaw_pkg.sv @@
package psaw_pkg;

  localparam int unsigned HistDepth = 32;
  localparam int unsigned WinW      = HistDepth;
  localparam int unsigned IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;

  localparam logic [15:0] HalfRange = 16'h8000;
  localparam logic [15:0] NoAck     = 16'hFFFF;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] rx_protocol;
    logic [15:0] rx_sequence;
    logic [15:0] rx_ack;
    logic [31:0] rx_ack_bits;
    logic [15:0] query_sequence;
  } item_t;

  typedef struct packed {
    logic [31:0] tx_protocol;
    logic [15:0] tx_sequence;
    logic [15:0] tx_ack;
    logic [31:0] tx_ack_bits;
    logic        accepted;
    logic        is_acked;
  } result_t;

  // a newer than b by half-range order, exactly half range only when a is larger
  function automatic logic seq_after(logic [15:0] a, logic [15:0] b);
    logic [15:0] diff;
    diff = a - b;
    return ((diff != 16'd0) && (diff < HalfRange)) || ((diff == HalfRange) && (a > b));
  endfunction

  // shift a window forward by d (nonzero) and mark the old newest
  function automatic logic [WinW-1:0] seq_advance(logic [WinW-1:0] mask, logic [15:0] d);
    logic [IdxW-1:0] sh;
    sh = d[IdxW-1:0];
    if (d >= 16'(HistDepth)) begin
      return '0;
    end
    return (mask << sh) | (WinW'(1) << (sh - IdxW'(1)));
  endfunction

endpackage

@@ rtl/psaw_core.sv @@
module psaw_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  psaw_pkg::item_t   item_i,
  input  logic [31:0]       protocol_id_i,
  output psaw_pkg::result_t result_o
);
  import psaw_pkg::*;

  logic [15:0]     next_tx_seq_q, next_tx_seq_d;
  logic [15:0]     remote_newest_q, remote_newest_d;
  logic [WinW-1:0] received_mask_q, received_mask_d;
  logic            remote_seen_q, remote_seen_d;
  logic [15:0]     peer_newest_q, peer_newest_d;
  logic [WinW-1:0] peer_mask_q, peer_mask_d;
  logic            peer_seen_q, peer_seen_d;

  logic [WinW-1:0] bits;
  logic [15:0]     ack_dist;
  logic [15:0]     rx_dist;
  logic [15:0]     rx_behind;
  logic [IdxW-1:0] rx_idx;
  logic [15:0]     q_behind;
  logic [IdxW-1:0] q_idx;
  logic            q_hit;

  assign bits      = item_i.rx_ack_bits[WinW-1:0];
  assign ack_dist  = item_i.rx_ack - peer_newest_q;
  assign rx_dist   = item_i.rx_sequence - remote_newest_q;
  assign rx_behind = remote_newest_q - item_i.rx_sequence;
  assign rx_idx    = IdxW'(rx_behind - 16'd1);
  assign q_behind  = peer_newest_q - item_i.query_sequence;
  assign q_idx     = IdxW'(q_behind - 16'd1);

  always_comb begin
    if (!peer_seen_q) begin
      q_hit = 1'b0;
    end else if (item_i.query_sequence == peer_newest_q) begin
      q_hit = 1'b1;
    end else if (seq_after(item_i.query_sequence, peer_newest_q)) begin
      q_hit = 1'b0;
    end else if (q_behind > 16'(HistDepth)) begin
      q_hit = 1'b0;
    end else begin
      q_hit = peer_mask_q[q_idx];
    end
  end

  always_comb begin
    next_tx_seq_d   = next_tx_seq_q;
    remote_newest_d = remote_newest_q;
    received_mask_d = received_mask_q;
    remote_seen_d   = remote_seen_q;
    peer_newest_d   = peer_newest_q;
    peer_mask_d     = peer_mask_q;
    peer_seen_d     = peer_seen_q;
    result_o        = '0;

    case (cmd_e'(item_i.cmd))
      CMD_SEND: begin
        result_o.tx_protocol = protocol_id_i;
        result_o.tx_sequence = next_tx_seq_q;
        result_o.tx_ack      = remote_seen_q ? remote_newest_q : NoAck;
        result_o.tx_ack_bits = remote_seen_q ? 32'(received_mask_q) : 32'd0;
        next_tx_seq_d        = next_tx_seq_q + 16'd1;
      end
      CMD_RECV: begin
        if (item_i.rx_protocol == protocol_id_i) begin
          // peer acks into the acked window
          if ((item_i.rx_ack != NoAck) || (item_i.rx_ack_bits != 32'd0)) begin
            if (!peer_seen_q) begin
              peer_newest_d = item_i.rx_ack;
              peer_mask_d   = bits;
              peer_seen_d   = 1'b1;
            end else if (seq_after(item_i.rx_ack, peer_newest_q)) begin
              peer_mask_d   = seq_advance(peer_mask_q, ack_dist) | bits;
              peer_newest_d = item_i.rx_ack;
            end else begin
              peer_mask_d = peer_mask_q | bits;
            end
          end
          // packet sequence into the receive window
          if (!remote_seen_q) begin
            remote_newest_d   = item_i.rx_sequence;
            received_mask_d   = '0;
            remote_seen_d     = 1'b1;
            result_o.accepted = 1'b1;
          end else if (item_i.rx_sequence == remote_newest_q) begin
            result_o.accepted = 1'b0;
          end else if (seq_after(item_i.rx_sequence, remote_newest_q)) begin
            received_mask_d   = seq_advance(received_mask_q, rx_dist);
            remote_newest_d   = item_i.rx_sequence;
            result_o.accepted = 1'b1;
          end else if (rx_behind > 16'(HistDepth)) begin
            result_o.accepted = 1'b0;
          end else if (received_mask_q[rx_idx]) begin
            result_o.accepted = 1'b0;
          end else begin
            received_mask_d         = received_mask_q;
            received_mask_d[rx_idx] = 1'b1;
            result_o.accepted       = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        result_o.is_acked = q_hit;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_tx_seq_q   <= '0;
      remote_newest_q <= '0;
      received_mask_q <= '0;
      remote_seen_q   <= 1'b0;
      peer_newest_q   <= '0;
      peer_mask_q     <= '0;
      peer_seen_q     <= 1'b0;
    end else if (step_i) begin
      next_tx_seq_q   <= next_tx_seq_d;
      remote_newest_q <= remote_newest_d;
      received_mask_q <= received_mask_d;
      remote_seen_q   <= remote_seen_d;
      peer_newest_q   <= peer_newest_d;
      peer_mask_q     <= peer_mask_d;
      peer_seen_q     <= peer_seen_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_peer_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(peer_seen_q))
    else $error("peer ack window lost its seen flag");

  a_remote_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(remote_seen_q))
    else $error("receive window lost its seen flag");

  a_send_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (item_i.cmd == CMD_SEND)) |=> (next_tx_seq_q == $past(next_tx_seq_q) + 16'd1))
    else $error("send counter did not advance");
`endif

endmodule

@@ rtl/packet_seq_ack_window.sv @@
// Sequence and ack tracking for one side of a packet link.
// s_axis carries one command item: tuser is the command (send, receive,
// query), tdata the received header fields and the query sequence.
// m_axis returns exactly one result item for each command item; fields a
// command does not use are zero, and an unknown command gives all zero.
// cfg_* writes the protocol id and is always ready. The user writes it only
// while no item is in flight; the block itself does not enforce this.
// An item taken from s_axis sits in the input register and moves to the
// result register once the result register is empty or m_axis takes the
// result it holds; the result is then on m_axis. One item is taken per
// cycle while m_axis does not stall; the state update is a single pass of
// compare, subtract and shift logic between those two registers.
// When m_axis stalls, the result register holds and the input register
// still takes one more item if it is empty before s_axis_tready drops.
// Reset clears both windows, the send counter and the protocol id; before
// any arrival a send header carries ack 0xFFFF and an empty mask.
module packet_seq_ack_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // rx_protocol, rx_sequence, rx_ack, rx_ack_bits, query_sequence
  input  logic [psaw_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic [psaw_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tx_protocol, tx_sequence, tx_ack, tx_ack_bits, accepted, is_acked, zero pad
  output logic [psaw_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);
  import psaw_pkg::*;

  logic        in_vld_q, in_vld_d;
  item_t       in_item_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_res_q;
  result_t     core_res;
  logic [31:0] protocol_id_q;
  logic        advance;
  logic        in_take;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_vld_d  = in_take || (in_vld_q && !advance);
  assign out_vld_d = advance ? in_vld_q : out_vld_q;

  psaw_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_vld_q && advance),
    .item_i        (in_item_q),
    .protocol_id_i (protocol_id_q),
    .result_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      protocol_id_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        protocol_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.cmd            <= s_axis_tuser[1:0];
      in_item_q.rx_protocol    <= s_axis_tdata[31:0];
      in_item_q.rx_sequence    <= s_axis_tdata[47:32];
      in_item_q.rx_ack         <= s_axis_tdata[63:48];
      in_item_q.rx_ack_bits    <= s_axis_tdata[95:64];
      in_item_q.query_sequence <= s_axis_tdata[111:96];
    end
    if (advance && in_vld_q) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid        = out_vld_q;
  assign m_axis_tdata[31:0]   = out_res_q.tx_protocol;
  assign m_axis_tdata[47:32]  = out_res_q.tx_sequence;
  assign m_axis_tdata[63:48]  = out_res_q.tx_ack;
  assign m_axis_tdata[95:64]  = out_res_q.tx_ack_bits;
  assign m_axis_tdata[96]     = out_res_q.accepted;
  assign m_axis_tdata[97]     = out_res_q.is_acked;
  assign m_axis_tdata[103:98] = '0;

`ifndef NO_ASSERTIONS
  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_vld_q))
    else $error("result appeared without an item in the input register");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_res_q.accepted && out_res_q.is_acked))
    else $error("accepted and is_acked both set");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("pending item dropped during stall");
`endif

endmodule

@@ dv/tb.sv @@
module tb;
  import psaw_pkg::*;

  localparam int unsigned Depth      = HistDepth;
  localparam logic [31:0] WinMask    = (HistDepth >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'd1 << HistDepth) - 32'd1);
  localparam logic [1:0]  CmdBad     = 2'd3;
  localparam int          CycleLimit = 5_000_000;
  localparam int          ShowLimit  = 10;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [31:0]         cfg_data_i    = '0;

  // header state as the block should hold it
  logic [31:0] proto_reg;
  logic [15:0] tx_next;
  logic [15:0] heard_newest;
  logic [31:0] heard_mask;
  logic        heard_any;
  logic [15:0] acked_newest;
  logic [31:0] acked_mask;
  logic        acked_any;

  result_t replies_due[$];

  int  n_bad      = 0;
  int  n_items    = 0;
  int  n_accept   = 0;
  int  n_acked    = 0;
  int  n_checked  = 0;
  int  cycles     = 0;
  int  burst_left = 0;
  bit  bursty     = 1'b1;
  int  rdy_left   = 0;
  bit  rdy_on     = 1'b0;

  packet_seq_ack_window i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("packet_seq_ack_window regression: fail");
      $finish;
    end
  end

  function automatic bit newer(logic [15:0] a, logic [15:0] b);
    return (a > b && (a - b) <= HalfRange) || (b > a && (b - a) > HalfRange);
  endfunction

  // move a history window forward by d and mark the old newest
  function automatic logic [31:0] slide(logic [31:0] m, logic [15:0] d);
    if (d >= Depth) begin
      return '0;
    end
    return ((m << d) | (32'd1 << (d - 16'd1))) & WinMask;
  endfunction

  function automatic result_t seq_ack_step(item_t it);
    result_t     r;
    logic [31:0] abits;
    logic [15:0] d;
    logic [15:0] behind;
    r = '0;
    case (it.cmd)
      CMD_SEND: begin
        r.tx_protocol = proto_reg;
        r.tx_sequence = tx_next;
        r.tx_ack      = heard_any ? heard_newest : NoAck;
        r.tx_ack_bits = heard_any ? heard_mask : '0;
        tx_next       = tx_next + 16'd1;
      end
      CMD_RECV: begin
        if (it.rx_protocol == proto_reg) begin
          if (!(it.rx_ack == NoAck && it.rx_ack_bits == '0)) begin
            abits = it.rx_ack_bits & WinMask;
            if (!acked_any) begin
              acked_newest = it.rx_ack;
              acked_mask   = abits;
              acked_any    = 1'b1;
            end else if (newer(it.rx_ack, acked_newest)) begin
              d            = it.rx_ack - acked_newest;
              acked_mask   = (d >= Depth) ? abits : (slide(acked_mask, d) | abits);
              acked_newest = it.rx_ack;
            end else begin
              acked_mask |= abits;
            end
          end
          if (!heard_any) begin
            heard_newest = it.rx_sequence;
            heard_mask   = '0;
            heard_any    = 1'b1;
            r.accepted   = 1'b1;
          end else if (it.rx_sequence == heard_newest) begin
            r.accepted = 1'b0;
          end else if (newer(it.rx_sequence, heard_newest)) begin
            heard_mask   = slide(heard_mask, it.rx_sequence - heard_newest);
            heard_newest = it.rx_sequence;
            r.accepted   = 1'b1;
          end else begin
            behind = heard_newest - it.rx_sequence;
            if (behind > Depth) begin
              r.accepted = 1'b0;
            end else if (heard_mask[behind - 16'd1]) begin
              r.accepted = 1'b0;
            end else begin
              heard_mask[behind - 16'd1] = 1'b1;
              r.accepted = 1'b1;
            end
          end
        end
      end
      CMD_QUERY: begin
        if (!acked_any) begin
          r.is_acked = 1'b0;
        end else if (it.query_sequence == acked_newest) begin
          r.is_acked = 1'b1;
        end else if (newer(it.query_sequence, acked_newest)) begin
          r.is_acked = 1'b0;
        end else begin
          behind = acked_newest - it.query_sequence;
          if (behind <= Depth) begin
            r.is_acked = acked_mask[behind - 16'd1];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic item_t hdr(logic [1:0] cmd, logic [31:0] proto, logic [15:0] seq,
                                logic [15:0] ack, logic [31:0] abits, logic [15:0] q);
    item_t it;
    it.cmd            = cmd;
    it.rx_protocol    = proto;
    it.rx_sequence    = seq;
    it.rx_ack         = ack;
    it.rx_ack_bits    = abits;
    it.query_sequence = q;
    return it;
  endfunction

  function automatic item_t rand_item(logic [1:0] cmd);
    return hdr(cmd, $urandom(), 16'($urandom()), 16'($urandom()), $urandom(),
               16'($urandom()));
  endfunction

  task automatic push_item(input item_t it);
    result_t want;
    int      gap;
    if (bursty && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.query_sequence, it.rx_ack_bits, it.rx_ack, it.rx_sequence,
                      it.rx_protocol};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    want = seq_ack_step(it);
    replies_due.push_back(want);
    n_items++;
    n_accept += want.accepted;
    n_acked  += want.is_acked;
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_proto(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    proto_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: runs of ready and stall, now and then a long ready stretch
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_on = !rdy_on;
      if (rdy_on) begin
        rdy_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end else begin
        rdy_left = $urandom_range(1, 6);
      end
    end
    rdy_left--;
    m_axis_tready <= rdy_on;
  end

  always @(posedge clk_i) begin : check_results
    result_t    got;
    result_t    want;
    logic [5:0] pad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tx_protocol = m_axis_tdata[31:0];
      got.tx_sequence = m_axis_tdata[47:32];
      got.tx_ack      = m_axis_tdata[63:48];
      got.tx_ack_bits = m_axis_tdata[95:64];
      got.accepted    = m_axis_tdata[96];
      got.is_acked    = m_axis_tdata[97];
      pad             = m_axis_tdata[103:98];
      if (replies_due.size() == 0) begin
        n_bad++;
        if (n_bad <= ShowLimit) begin
          $display("unexpected result: tdata %h", m_axis_tdata);
        end
      end else begin
        want = replies_due.pop_front();
        if (got.tx_protocol !== want.tx_protocol || got.tx_sequence !== want.tx_sequence ||
            got.tx_ack !== want.tx_ack || got.tx_ack_bits !== want.tx_ack_bits ||
            got.accepted !== want.accepted || got.is_acked !== want.is_acked ||
            pad !== '0) begin
          n_bad++;
          if (n_bad <= ShowLimit) begin
            $display("result %0d: want proto %h seq %h ack %h bits %h acc %b acked %b",
                     n_checked, want.tx_protocol, want.tx_sequence, want.tx_ack,
                     want.tx_ack_bits, want.accepted, want.is_acked);
            $display("           got  proto %h seq %h ack %h bits %h acc %b acked %b pad %h",
                     got.tx_protocol, got.tx_sequence, got.tx_ack, got.tx_ack_bits,
                     got.accepted, got.is_acked, pad);
          end
        end
      end
      n_checked++;
    end
  end

  task automatic check_header_cases();
    logic [31:0] p;
    p = 32'hFFFF_FFFF;
    push_item(hdr(CMD_SEND, '0, '0, '0, '0, '0));
    write_proto(p);
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd0));
    push_item(hdr(CmdBad, '1, '1, '1, '1, '1));
    // wrong protocol leaves everything alone
    push_item(hdr(CMD_RECV, 32'h0, 16'd100, NoAck, '0, '0));
    // first arrival, header without acks
    push_item(hdr(CMD_RECV, p, 16'd100, NoAck, '0, '0));
    push_item(hdr(CMD_SEND, '0, '0, '0, '0, '0));
    push_item(hdr(CMD_RECV, p, 16'd100, NoAck, '0, '0));
    // first ack
    push_item(hdr(CMD_RECV, p, 16'd101, 16'd0, '0, '0));
    push_item(hdr(CMD_RECV, p, 16'd99, NoAck, '0, '0));
    push_item(hdr(CMD_RECV, p, 16'd99, NoAck, '0, '0));
    // one past the window, then its oldest slot
    push_item(hdr(CMD_RECV, p, 16'd68, NoAck, '0, '0));
    push_item(hdr(CMD_RECV, p, 16'd69, NoAck, '0, '0));
    push_item(hdr(CMD_SEND, '0, '0, '0, '0, '0));
    // sequence jump clears history, ack moves ahead
    push_item(hdr(CMD_RECV, p, 16'd133, 16'd5, 32'h0000_000F, '0));
    // older ack ors in without realignment
    push_item(hdr(CMD_RECV, p, 16'd134, 16'd3, 32'h8000_0000, '0));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd5));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd6));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd0));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd65509));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd65508));
    push_item(hdr(CMD_RECV, p, 16'hFFFF, NoAck, '1, '0));
    // exactly half range ahead, both ways
    push_item(hdr(CMD_RECV, p, 16'h8086, 16'd45, 32'h1, '0));
    push_item(hdr(CMD_RECV, p, 16'd134, 16'd46, '0, '0));
    push_item(hdr(CMD_SEND, '0, '0, '0, '0, '0));
    push_item(hdr(CMD_QUERY, '0, '0, '0, '0, 16'd45));
  endtask

  task automatic check_send_burst();
    write_proto(32'h0);
    bursty = 1'b0;
    repeat (100) push_item(rand_item(CMD_SEND));
    bursty = 1'b1;
  endtask

  task automatic check_random_traffic();
    item_t       it;
    int          r;
    int          s;
    logic [31:0] phase_proto [4];
    phase_proto = '{$urandom(), 32'h0, 32'hFFFF_FFFF, $urandom()};
    for (int ph = 0; ph < 4; ph++) begin
      write_proto(phase_proto[ph]);
      for (int k = 0; k < 320; k++) begin
        r = $urandom_range(0, 99);
        if (r < 28) begin
          it = rand_item(CMD_SEND);
        end else if (r < 75) begin
          it = rand_item(CMD_RECV);
          if ($urandom_range(0, 19) != 0) begin
            it.rx_protocol = proto_reg;
          end
          s = $urandom_range(0, 99);
          if (s < 55) begin
            it.rx_sequence = heard_newest + 16'd1;
          end else if (s < 65) begin
            it.rx_sequence = heard_newest;
          end else if (s < 82) begin
            it.rx_sequence = heard_newest - 16'($urandom_range(1, 34));
          end else if (s < 95) begin
            it.rx_sequence = heard_newest + 16'($urandom_range(2, 40));
          end
          s = $urandom_range(0, 99);
          if (s < 10) begin
            it.rx_ack      = NoAck;
            it.rx_ack_bits = '0;
          end else if (s < 90) begin
            it.rx_ack = tx_next - 16'($urandom_range(1, 40));
            case ($urandom_range(0, 3))
              0: it.rx_ack_bits = '0;
              1: it.rx_ack_bits = '1;
              2: it.rx_ack_bits = $urandom() & $urandom();
              default: begin
              end
            endcase
          end
        end else if (r < 92) begin
          it = rand_item(CMD_QUERY);
          s = $urandom_range(0, 99);
          if (s < 75) begin
            it.query_sequence = acked_newest - 16'($urandom_range(0, 36));
          end else if (s < 88) begin
            it.query_sequence = acked_newest + 16'($urandom_range(1, 5));
          end
        end else begin
          it = rand_item(2'($urandom_range(0, 3)));
        end
        push_item(it);
        if (ph == 1 && k == 175) begin
          drain();
        end
      end
    end
  endtask

  initial begin
    proto_reg    = '0;
    tx_next      = '0;
    heard_newest = '0;
    heard_mask   = '0;
    heard_any    = 1'b0;
    acked_newest = '0;
    acked_mask   = '0;
    acked_any    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_header_cases();
    check_send_burst();
    check_random_traffic();
    drain();
    repeat (8) @(posedge clk_i);
    $display("ran %0d items in %0d cycles: header corner cases, a back to back send run,",
             n_items, cycles);
    $display("four protocol id phases of mixed traffic; %0d receives accepted, %0d acked",
             n_accept, n_acked);
    $display("%0d results checked, %0d bad", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("packet_seq_ack_window regression: pass");
    end else begin
      $display("packet_seq_ack_window regression: fail");
    end
    $finish;
  end

endmodule
